// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers shared by the formatter modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked property, disabled while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked property, checked during reset as well
`define ASSERT_CLK_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_CLK_ALL(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/ddf_pkg.sv -----
// ----------------------------------------------------------------------------
// ddf_pkg
// types and constants of the decimal digit formatter
// ----------------------------------------------------------------------------
package ddf_pkg;

  localparam int FIELD_LEN = 6;

  typedef logic [5:0] char_t;
  typedef logic [2:0] idx_t;

  localparam idx_t  LAST_IDX  = 3'd5;
  localparam idx_t  MAX_POINT = 3'd5;
  localparam char_t CH_SPACE  = 6'd32;
  localparam char_t CH_POINT  = 6'd46;
  localparam char_t CH_ZERO   = 6'd48;

  // reciprocals for exact floor division of a 16-bit value
  localparam logic [16:0] RECIP_10    = 17'd52429;   // shift 19
  localparam logic [16:0] RECIP_100   = 17'd83887;   // shift 23
  localparam logic [16:0] RECIP_1000  = 17'd67109;   // shift 26
  localparam logic [16:0] RECIP_10000 = 17'd107375;  // shift 30

  // register word index
  localparam logic REG_SKIP_BLANKS = 1'b0;

  // quotients of one value by 10, 100, 1000, 10000
  typedef struct packed {
    logic [2:0]  q4;
    logic [6:0]  q3;
    logic [9:0]  q2;
    logic [12:0] q1;
    logic [15:0] v;
    logic [2:0]  pos;
  } quot_t;

  typedef struct packed {
    logic [FIELD_LEN-1:0][5:0] chars;
    idx_t                      start;
  } field_t;

endpackage

// ----- hw/rtl/decimal_digit_formatter.sv -----
// ----------------------------------------------------------------------------
// decimal_digit_formatter
// 16-bit binary value to a six-character ascii decimal field with point
// ----------------------------------------------------------------------------
// path: input register, quotient register, then the output character buffer
// throughput: one character per cycle while m_tready is high; a value sends 1 to 6
//   characters, one per character held in the output character buffer
// reset: synchronous, clears all valid flags and skip_blanks to 0
// ----------------------------------------------------------------------------
module decimal_digit_formatter (
  input  logic        clk,
  input  logic        rst,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] value, [18:16] point_pos, [23:19] zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [5:0] char_code, [7:6] zero
  output logic        m_tlast    // last
);
  import ddf_pkg::*;

  logic   skip_blanks;
  logic   q_valid;
  logic   q_ready;
  quot_t  q_data;
  field_t field;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_blanks <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SKIP_BLANKS) begin
      skip_blanks <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_SKIP_BLANKS) ? {31'd0, skip_blanks} : 32'd0;

  ddf_digit_split u_split (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .value     (s_tdata[15:0]),
    .point_pos (s_tdata[18:16]),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data)
  );

  ddf_field_build u_build (
    .q_data      (q_data),
    .skip_blanks (skip_blanks),
    .field       (field)
  );

  ddf_char_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .f_valid  (q_valid),
    .f_ready  (q_ready),
    .field    (field),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- hw/rtl/ddf_digit_split.sv -----
// ----------------------------------------------------------------------------
// ddf_digit_split
// input register and reciprocal multipliers giving the decimal quotients
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddf_digit_split (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  logic [15:0]   value,
  input  logic [2:0]    point_pos,
  output logic          q_valid,
  input  logic          q_ready,
  output ddf_pkg::quot_t q_data
);
  import ddf_pkg::*;

  logic        in_valid;
  logic [15:0] in_value;
  logic [2:0]  in_pos;
  logic        quot_valid;
  quot_t       quot;
  quot_t       quot_next;
  logic        quot_load_ok;
  logic [32:0] p1, p2, p3, p4;
  logic [16:0] units_rem;
  logic [12:0] tens_rem;

  assign quot_load_ok = !quot_valid || q_ready;
  assign s_ready      = !in_valid || quot_load_ok;

  always_comb begin
    p1 = {17'd0, in_value} * {16'd0, RECIP_10};
    p2 = {17'd0, in_value} * {16'd0, RECIP_100};
    p3 = {17'd0, in_value} * {16'd0, RECIP_1000};
    p4 = {17'd0, in_value} * {16'd0, RECIP_10000};
    quot_next.q1  = p1[31:19];
    quot_next.q2  = p2[32:23];
    quot_next.q3  = p3[32:26];
    quot_next.q4  = p4[32:30];
    quot_next.v   = in_value;
    quot_next.pos = in_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      quot_valid <= 1'b0;
    end else begin
      if (s_ready) begin
        in_valid <= s_valid;
      end
      if (quot_load_ok) begin
        quot_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      in_value <= value;
      in_pos   <= point_pos;
    end
    if (in_valid && quot_load_ok) begin
      quot <= quot_next;
    end
  end

  assign q_valid = quot_valid;
  assign q_data  = quot;

  assign units_rem = {1'b0, quot.v} - ({4'd0, quot.q1} * 17'd10);
  assign tens_rem  = quot.q1 - ({3'd0, quot.q2} * 13'd10);

  `ASSERT_CLK(a_q4_range, clk, rst, quot_valid |-> (quot.q4 <= 3'd6), "leading digit over 6")
  `ASSERT_CLK(a_q1_rem, clk, rst, quot_valid |-> (units_rem < 17'd10), "units digit over 9")
  `ASSERT_CLK(a_q2_rem, clk, rst, quot_valid |-> (tens_rem < 13'd10), "tens digit over 9")

endmodule

// ----- hw/rtl/ddf_field_build.sv -----
// ----------------------------------------------------------------------------
// ddf_field_build
// digit extraction, point placement, leading-zero blanking and start index
// ----------------------------------------------------------------------------
module ddf_field_build (
  input  ddf_pkg::quot_t  q_data,
  input  logic            skip_blanks,
  output ddf_pkg::field_t field
);
  import ddf_pkg::*;

  logic [3:0] dig [5];
  logic [6:0] t3, diff3;
  logic [9:0] t2, diff2;
  logic [12:0] t1, diff1;
  logic [15:0] t0, diff0;
  logic [2:0] p;
  logic [2:0] k;
  logic [3:0] raw;
  logic       blanking;
  logic       found;
  logic [FIELD_LEN-1:0][5:0] ch;

  // digits from neighboring quotients, most significant in dig[4]
  always_comb begin
    t3    = {4'd0, q_data.q4} * 7'd10;
    diff3 = q_data.q3 - t3;
    t2    = {3'd0, q_data.q3} * 10'd10;
    diff2 = q_data.q2 - t2;
    t1    = {3'd0, q_data.q2} * 13'd10;
    diff1 = q_data.q1 - t1;
    t0    = {3'd0, q_data.q1} * 16'd10;
    diff0 = q_data.v - t0;
    dig[4] = {1'b0, q_data.q4};
    dig[3] = diff3[3:0];
    dig[2] = diff2[3:0];
    dig[1] = diff1[3:0];
    dig[0] = diff0[3:0];
  end

  always_comb begin
    p = (q_data.pos > MAX_POINT) ? 3'd0 : q_data.pos;
    blanking = 1'b1;
    ch = '0;
    k = '0;
    raw = '0;
    for (int i = 0; i < FIELD_LEN; i++) begin
      // digit slot skips over the point; with no point a zero leads
      if (p != 3'd0 && 3'(i) < p) begin
        k = 3'(4 - i);
      end else begin
        k = 3'(5 - i);
      end
      if (p == 3'd0 && i == 0) begin
        raw = 4'd0;
      end else begin
        raw = dig[k];
      end
      if (p != 3'd0 && 3'(i) == p) begin
        ch[i] = CH_POINT;
      end else if (p != 3'd0 && 3'(i + 1) == p && blanking) begin
        ch[i] = CH_ZERO + {2'b00, raw};
        blanking = 1'b0;
      end else if (blanking && raw == 4'd0) begin
        ch[i] = CH_SPACE;
      end else begin
        blanking = 1'b0;
        ch[i] = CH_ZERO + {2'b00, raw};
      end
    end
    // zero value with no point
    if (blanking) begin
      ch[FIELD_LEN-1] = CH_ZERO;
    end
  end

  always_comb begin
    field.chars = ch;
    field.start = '0;
    found = 1'b0;
    if (skip_blanks) begin
      for (int i = 0; i < FIELD_LEN - 1; i++) begin
        if (!found) begin
          if (ch[i] == CH_SPACE) begin
            field.start = 3'(i + 1);
          end else begin
            found = 1'b1;
          end
        end
      end
    end
  end

endmodule

// ----- hw/rtl/ddf_char_emit.sv -----
// ----------------------------------------------------------------------------
// ddf_char_emit
// field buffer that sends one character per transaction, last one flagged
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddf_char_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            f_valid,
  output logic            f_ready,
  input  ddf_pkg::field_t field,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);
  import ddf_pkg::*;

  logic                      buf_valid;
  logic [FIELD_LEN-1:0][5:0] chars;
  idx_t                      idx;
  logic                      at_last;
  logic                      take;

  assign at_last = (idx == LAST_IDX);
  assign take    = buf_valid && m_tready;
  // a new field loads as the final character of the previous one leaves
  assign f_ready = !buf_valid || (m_tready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (f_valid && f_ready) begin
      buf_valid <= 1'b1;
    end else if (take && at_last) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (f_valid && f_ready) begin
      chars <= field.chars;
      idx   <= field.start;
    end else if (take && !at_last) begin
      idx <= idx + 3'd1;
    end
  end

  assign m_tvalid = buf_valid;
  assign m_tdata  = {2'b00, chars[idx]};
  assign m_tlast  = at_last;

  `ASSERT_CLK(a_field_continues, clk, rst, (take && !at_last) |=> buf_valid, "field cut short")
  `ASSERT_CLK(a_last_not_blank, clk, rst, (buf_valid && at_last) |-> (chars[idx] != CH_SPACE), "final character is blank")
  `ASSERT_CLK(a_start_range, clk, rst, (f_valid && f_ready) |=> (buf_valid && idx <= LAST_IDX), "start index out of range")

endmodule
